FILE: rtl/flow_shop_schedule_evaluator_top_assert.svh
// Assertion macros used by the flow-shop schedule evaluator top level.
`ifndef FLOW_SHOP_SCHEDULE_EVALUATOR_TOP_ASSERT_SVH
`define FLOW_SHOP_SCHEDULE_EVALUATOR_TOP_ASSERT_SVH

// A vector must have exactly one bit set at every clock edge out of reset.
`define FSSE_ASSERT_ONEHOT(label, clk, rst, sig) \
   label: assert property (@(posedge clk) disable iff (rst) $onehot(sig)) \
      else $error("one-hot check failed");

// An antecedent in one cycle implies a consequent in the next cycle.
`define FSSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// An antecedent implies a consequent in the same cycle.
`define FSSE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

`endif

FILE: rtl/fsse_pkg.sv
// Shared constants, types and helper functions of the flow-shop evaluator.
package fsse_pkg;

   localparam int MAX_MACHINES = 16;
   localparam int MIDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
   localparam int NM_W = 5;
   localparam int TIME_W = 32;
   localparam int PROC_W = 16;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic [ADDR_W-1:0] REG_NUM_MACHINES = 3'd0;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic                accept;
      logic                cfg_wr;
      logic [MIDX_W-1:0]   last_idx;
      logic [TIME_W-1:0]   c_new;
   } cell_ctl_type;

   // One job finished on its last machine, handed to the result pipeline.
   typedef struct packed {
      logic [TIME_W-1:0] completion;
      logic [TIME_W-1:0] due;
      logic              first;
      logic              last;
   } job_type;

   // Index of the last active machine after clamping the count to 1..MAX_MACHINES.
   function automatic logic [MIDX_W-1:0] last_index(input logic [NM_W-1:0] nm);
      logic [7:0] m;
      m = {3'b000, nm};
      if (m == 8'd0) m = 8'd1;
      if (m > 8'(MAX_MACHINES)) m = 8'(MAX_MACHINES);
      return MIDX_W'(m - 8'd1);
   endfunction

   function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
   endfunction

endpackage

FILE: rtl/flow_shop_schedule_evaluator_top.sv
// Top level of the permutation flow-shop schedule evaluator.
//
// The evaluator takes one transaction per machine of each job, machine 0 first, and
// accepts a new transaction in every clock cycle while the result side keeps up.
// Every machine owns one cell in a chain; the cells hold the previous job's
// completion on their machine, and a single token walks down the chain one cell per
// accepted transaction, wrapping back to cell 0 after the last configured machine.
// The max-plus-add of a transaction happens in the cycle in which it is accepted,
// so a job's machines follow one another with no gap. On the last machine a result
// enters a three-register pipeline (input, tardiness, output register with the running
// sum); rsp_valid rises once the result reaches the output register. The block keeps
// accepting transactions until three results wait for rsp_ready, and then stalls every
// transaction until one leaves. Completion and the tardiness sum saturate at all ones.
// Writing num_machines (address 0) returns the token to machine 0; values of 0 act
// as one machine and values above the cell count act as the full chain.
module flow_shop_schedule_evaluator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fsse_pkg::PROC_W-1:0]        req_proc_time,
   input  logic [fsse_pkg::TIME_W-1:0]        req_due_date,
   input  logic                               req_first_job,
   input  logic                               req_last_job,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fsse_pkg::TIME_W-1:0]        rsp_job_completion,
   output logic [fsse_pkg::TIME_W-1:0]        rsp_job_tardiness,
   output logic [fsse_pkg::TIME_W-1:0]        rsp_total_tardiness,
   output logic                               rsp_schedule_done,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fsse_pkg::ADDR_W-1:0]        paddr,
   input  logic [fsse_pkg::DATA_W-1:0]        pwdata,
   output logic [fsse_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);

`include "flow_shop_schedule_evaluator_top_assert.svh"

   localparam int N = fsse_pkg::MAX_MACHINES;

   // Configuration register. Only the register index bit of the address is decoded.
   logic [fsse_pkg::NM_W-1:0] nm_ff, nm_in;
   logic                      cfg_wr;
   logic                      reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == fsse_pkg::REG_NUM_MACHINES[2]);
   assign cfg_wr  = psel & penable & pwrite & reg_hit;
   assign nm_in   = cfg_wr ? pwdata[fsse_pkg::NM_W-1:0] : nm_ff;
   assign prdata  = reg_hit ? {{(fsse_pkg::DATA_W-fsse_pkg::NM_W){1'b0}}, nm_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_ff <= fsse_pkg::NM_W'(1);
      end else begin
         nm_ff <= nm_in;
      end
   end

   // This job's completion on the previous machine.
   logic [fsse_pkg::TIME_W-1:0] up_ff, up_in;

   logic                        accept;
   logic                        res_ready;
   fsse_pkg::cell_ctl_type      ctl;
   logic [N-1:0]                tok_next, tok_wrap, tok_here;
   logic [N-1:0]                tok_prev;
   logic [fsse_pkg::TIME_W-1:0] comp_sel [N];
   logic [fsse_pkg::TIME_W-1:0] prev_job, prev_mach, start;
   logic [fsse_pkg::TIME_W-1:0] c_new;
   logic                        job_end;
   fsse_pkg::job_type           job;

   // The whole datapath waits on the result pipeline, so a last-machine
   // transaction is only taken when its result has room.
   assign req_ready = res_ready;
   assign accept    = req_valid & req_ready;

   // Cell outputs are zero away from the token, so an OR picks the current machine.
   always_comb begin
      prev_job = '0;
      for (int k = 0; k < N; k++) begin
         prev_job = prev_job | comp_sel[k];
      end
      if (req_first_job) begin
         prev_job = '0;
      end
   end

   assign prev_mach = tok_here[0] ? '0 : up_ff;
   assign start     = (prev_job > prev_mach) ? prev_job : prev_mach;
   assign c_new     = fsse_pkg::add_sat(start, {{(fsse_pkg::TIME_W-fsse_pkg::PROC_W){1'b0}},
                                                req_proc_time});
   assign job_end   = |tok_wrap;
   assign up_in     = accept ? c_new : up_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= '0;
      end else begin
         up_ff <= up_in;
      end
   end

   assign ctl.accept   = accept;
   assign ctl.cfg_wr   = cfg_wr;
   assign ctl.last_idx = fsse_pkg::last_index(nm_ff);
   assign ctl.c_new    = c_new;

   // The token of the last active cell returns to the head of the chain.
   assign tok_prev[0] = job_end;

   genvar i;
   generate
      for (i = 1; i < N; i++) begin : g_link
         assign tok_prev[i] = tok_next[i-1];
      end
      for (i = 0; i < N; i++) begin : g_cell
         fsse_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (fsse_pkg::MIDX_W'(i)),
            .ctl      (ctl),
            .tok_prev (tok_prev[i]),
            .tok_next (tok_next[i]),
            .tok_wrap (tok_wrap[i]),
            .tok_here (tok_here[i]),
            .comp_sel (comp_sel[i])
         );
      end
   endgenerate

   assign job.completion = c_new;
   assign job.due        = req_due_date;
   assign job.first      = req_first_job;
   assign job.last       = req_last_job;

   fsse_result u_result (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (accept & job_end),
      .in_job         (job),
      .in_ready       (res_ready),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_completion (rsp_job_completion),
      .out_tardiness  (rsp_job_tardiness),
      .out_total      (rsp_total_tardiness),
      .out_done       (rsp_schedule_done)
   );

   // Exactly one machine holds the token at all times.
   `FSSE_ASSERT_ONEHOT(a_tok_onehot, clock, reset, tok_here)
   // A register write always restarts the job at machine 0.
   `FSSE_ASSERT_NEXT(a_cfg_restart, clock, reset, cfg_wr, tok_here[0])
   // The running sum includes the job's own tardiness.
   `FSSE_ASSERT_SAME(a_total_ge, clock, reset, rsp_valid,
                     rsp_total_tardiness >= rsp_job_tardiness)

endmodule

FILE: rtl/fsse_cell.sv
// One machine cell: holds the previous job's completion and the machine token.
module fsse_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [fsse_pkg::MIDX_W-1:0]  cell_idx,
   input  fsse_pkg::cell_ctl_type       ctl,
   input  logic                         tok_prev,
   output logic                         tok_next,
   output logic                         tok_wrap,
   output logic                         tok_here,
   output logic [fsse_pkg::TIME_W-1:0]  comp_sel
);

   logic                        tok_ff, tok_in;
   logic [fsse_pkg::TIME_W-1:0] comp_ff, comp_in;
   logic                        is_last;

   assign is_last  = (cell_idx == ctl.last_idx);
   assign tok_next = tok_ff & ~is_last;
   assign tok_wrap = tok_ff & is_last;
   assign tok_here = tok_ff;
   assign comp_sel = tok_ff ? comp_ff : '0;

   always_comb begin
      tok_in  = tok_ff;
      comp_in = comp_ff;
      if (ctl.cfg_wr) begin
         tok_in = (cell_idx == '0);
      end else if (ctl.accept) begin
         tok_in = tok_prev;
         if (tok_ff) begin
            comp_in = ctl.c_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= (cell_idx == '0);
         comp_ff <= '0;
      end else begin
         tok_ff  <= tok_in;
         comp_ff <= comp_in;
      end
   end

endmodule

FILE: rtl/fsse_result.sv
// Result pipeline: tardiness, running tardiness sum and the output register.
module fsse_result (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  fsse_pkg::job_type            in_job,
   output logic                         in_ready,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [fsse_pkg::TIME_W-1:0]  out_completion,
   output logic [fsse_pkg::TIME_W-1:0]  out_tardiness,
   output logic [fsse_pkg::TIME_W-1:0]  out_total,
   output logic                         out_done
);

   logic                        a_v_ff, a_v_in;
   fsse_pkg::job_type           a_job_ff;
   logic                        b_v_ff, b_v_in;
   logic [fsse_pkg::TIME_W-1:0] b_comp_ff, b_tard_ff, b_tard_in;
   logic                        b_first_ff, b_last_ff;
   logic                        o_v_ff, o_v_in;
   logic [fsse_pkg::TIME_W-1:0] o_comp_ff, o_tard_ff, o_total_ff;
   logic                        o_done_ff;
   logic [fsse_pkg::TIME_W-1:0] sum_ff, sum_in;
   logic                        o_rdy, b_rdy, a_rdy;
   logic                        a_load, b_load, o_load;

   assign o_rdy    = ~o_v_ff | out_ready;
   assign b_rdy    = ~b_v_ff | o_rdy;
   assign a_rdy    = ~a_v_ff | b_rdy;
   assign in_ready = a_rdy;

   assign a_load = a_rdy;
   assign b_load = b_rdy;
   assign o_load = o_rdy;

   assign a_v_in = a_load ? in_valid : a_v_ff;
   assign b_v_in = b_load ? a_v_ff : b_v_ff;
   assign o_v_in = o_load ? b_v_ff : o_v_ff;

   assign b_tard_in = (a_job_ff.completion > a_job_ff.due) ?
                      (a_job_ff.completion - a_job_ff.due) : '0;

   assign sum_in = fsse_pkg::add_sat(b_first_ff ? '0 : sum_ff, b_tard_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         sum_ff <= '0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= b_v_in;
         o_v_ff <= o_v_in;
         if (o_load && b_v_ff) begin
            sum_ff <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && in_valid) begin
         a_job_ff <= in_job;
      end
      if (b_load && a_v_ff) begin
         b_comp_ff  <= a_job_ff.completion;
         b_tard_ff  <= b_tard_in;
         b_first_ff <= a_job_ff.first;
         b_last_ff  <= a_job_ff.last;
      end
      if (o_load && b_v_ff) begin
         o_comp_ff  <= b_comp_ff;
         o_tard_ff  <= b_tard_ff;
         o_total_ff <= sum_in;
         o_done_ff  <= b_last_ff;
      end
   end

   assign out_valid      = o_v_ff;
   assign out_completion = o_comp_ff;
   assign out_tardiness  = o_tard_ff;
   assign out_total      = o_total_ff;
   assign out_done       = o_done_ff;

endmodule
